>>> rtl/core/rlim_pkg.sv
package rlim_pkg;

  // Default sizes; the top level hands its parameters down.
  localparam int MAX_RECORDS_DEF   = 256;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int POS_W             = 32;

  // Operation codes.
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] start_position;
    logic [31:0] range_count;
    logic [31:0] run_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        is_run;
    logic [31:0] span_start;
    logic [31:0] span_length;
    logic [31:0] span_value;
    logic        fail;
    logic [31:0] line_length;
    logic [31:0] first_used;
  } out_item_t;

  // Memory requests from the sequencer; the bank bits pick one of the two banks.
  typedef struct packed {
    logic rd_en;
    logic rd_bank;
    logic wr_en;
    logic wr_bank;
  } mem_ctl_t;

endpackage

>>> rtl/core/rlim_bank.sv
module rlim_bank #(
  parameter int DEPTH = rlim_pkg::MAX_RECORDS_DEF,
  parameter int WIDTH = 2 * rlim_pkg::POS_W + rlim_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/rlim_seq.sv
module rlim_seq #(
  parameter int MAX_RECORDS   = rlim_pkg::MAX_RECORDS_DEF,
  parameter int PAYLOAD_WIDTH = rlim_pkg::PAYLOAD_WIDTH_DEF,
  localparam int AW = $clog2(MAX_RECORDS),
  localparam int RW = 2 * rlim_pkg::POS_W + PAYLOAD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rlim_pkg::in_item_t  in_item,
  output logic                busy,
  output rlim_pkg::mem_ctl_t  mem_ctl,
  output logic [AW-1:0]       rd_addr,
  output logic [AW-1:0]       wr_addr,
  output logic [RW-1:0]       wr_data,
  input  logic [RW-1:0]       rd_data,
  output logic                out_strobe,
  output rlim_pkg::out_item_t out_item
);

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int PW = PAYLOAD_WIDTH;
  localparam int BW = rlim_pkg::POS_W + AW + 2;
  localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_RECORDS);
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEL  = 4'd1;
  localparam logic [3:0] S_FIND = 4'd2;
  localparam logic [3:0] S_ACT  = 4'd3;
  localparam logic [3:0] S_COPY = 4'd4;
  localparam logic [3:0] S_SPEC = 4'd5;
  localparam logic [3:0] S_FIN0 = 4'd6;
  localparam logic [3:0] S_FIN1 = 4'd7;

  // Control state.
  logic [3:0]  state_r, state_nxt;
  logic        cur_r, cur_nxt;
  logic        wb_r, wb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] end_r, end_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic        out_strobe_r, out_strobe_nxt;

  // Work registers.
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   s_r, s_nxt;
  logic [31:0]   n_r, n_nxt;
  logic [31:0]   dn_r, dn_nxt;
  logic [32:0]   e_r, e_nxt;
  logic [PW-1:0] v_r, v_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic [31:0]   wend_r, wend_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] rd_ix_r, rd_ix_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [BW-1:0] pos_r, pos_nxt;
  logic [BW-1:0] carry_r, carry_nxt;
  logic [BW-1:0] base_r, base_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] fidx_r, fidx_nxt;
  logic [31:0]   fg_r, fg_nxt;
  logic [31:0]   fl_r, fl_nxt;
  logic [PW-1:0] fp_r, fp_nxt;
  logic [31:0]   frs_r, frs_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [1:0]    spc_r, spc_nxt;
  logic [RW-1:0] sp_r [3];
  logic [RW-1:0] sp_nxt [3];
  rlim_pkg::out_item_t out_item_r, out_item_nxt;

  // Fields of the record being read.
  logic [31:0]   d_gap, d_len;
  logic [PW-1:0] d_pay;

  assign d_gap = rd_data[RW-1 -: 32];
  assign d_len = rd_data[RW-33 -: 32];
  assign d_pay = rd_data[PW-1:0];

  function automatic logic [BW-1:0] overlap(input logic [BW-1:0] a0, input logic [BW-1:0] a1,
                                            input logic [BW-1:0] b0, input logic [BW-1:0] b1);
    logic [BW-1:0] lo, hi;
    begin
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      overlap = (hi > lo) ? hi - lo : '0;
    end
  endfunction

  // Sequencer: delete and/or search pass, then any in-place write or copy pass.
  always_comb begin
    logic [31:0]   room_s, room_e, n_set, n_ins, n_eff, avail, dn;
    logic          do_del, is_mod;
    logic [63:0]   v64, p64;
    logic [BW-1:0] ge, re_, ovg, ovl, ng, nl, nxt_base;
    logic          hit, miss_done, issue;
    logic [31:0]   off, head;
    logic          split, room1, room2;
    logic [32:0]   rstart;
    logic [CW-1:0] dst;
    logic [CW-1:0] spc_addr;

    state_nxt      = state_r;
    cur_nxt        = cur_r;
    wb_nxt         = wb_r;
    cnt_nxt        = cnt_r;
    end_nxt        = end_r;
    rd_vld_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    op_nxt         = op_r;
    s_nxt          = s_r;
    n_nxt          = n_r;
    dn_nxt         = dn_r;
    e_nxt          = e_r;
    v_nxt          = v_r;
    wcnt_nxt       = wcnt_r;
    wend_nxt       = wend_r;
    rd_idx_nxt     = rd_idx_r;
    rd_ix_nxt      = rd_ix_r;
    wr_idx_nxt     = wr_idx_r;
    pos_nxt        = pos_r;
    carry_nxt      = carry_r;
    base_nxt       = base_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    fg_nxt         = fg_r;
    fl_nxt         = fl_r;
    fp_nxt         = fp_r;
    frs_nxt        = frs_r;
    k_nxt          = k_r;
    spc_nxt        = spc_r;
    sp_nxt         = sp_r;
    out_item_nxt   = out_item_r;
    mem_ctl        = '0;
    rd_addr        = '0;
    wr_addr        = '0;
    wr_data        = '0;

    room_s = POS_MAX - in_item.start_position;
    room_e = POS_MAX - end_r;
    n_set  = (in_item.range_count > room_s) ? room_s : in_item.range_count;
    n_ins  = (in_item.range_count > room_e) ? room_e : in_item.range_count;
    n_eff  = (in_item.op == rlim_pkg::OP_SET) ? n_set :
             (in_item.op == rlim_pkg::OP_INSERT) ? n_ins : in_item.range_count;
    avail  = end_r - in_item.start_position;
    dn     = (n_eff > avail) ? avail : n_eff;
    is_mod = (in_item.op == rlim_pkg::OP_SET) || (in_item.op == rlim_pkg::OP_CLEAR) ||
             (in_item.op == rlim_pkg::OP_DELETE) || (in_item.op == rlim_pkg::OP_INSERT);
    do_del = ((in_item.op == rlim_pkg::OP_SET) || (in_item.op == rlim_pkg::OP_CLEAR) ||
              (in_item.op == rlim_pkg::OP_DELETE)) && (n_eff != '0) &&
             (in_item.start_position < end_r);
    v64    = 64'(in_item.run_value);
    p64    = 64'(fp_r);

    ge       = pos_r + BW'(d_gap);
    re_      = ge + BW'(d_len);
    ovg      = overlap(pos_r, ge, BW'(s_r), BW'(e_r));
    ovl      = overlap(ge, re_, BW'(s_r), BW'(e_r));
    ng       = BW'(d_gap) - ovg;
    nl       = BW'(d_len) - ovl;
    nxt_base = base_r + BW'(d_gap) + BW'(d_len);
    hit      = rd_vld_r && (BW'(s_r) < nxt_base);
    miss_done = !rd_vld_r && ((rd_idx_r >= wcnt_r) || (s_r >= wend_r));
    issue    = 1'b0;

    off      = s_r - frs_r;
    split    = off > fg_r;
    head     = off - fg_r;
    room1    = {1'b0, wcnt_r} + (CW + 1)'(1) <= MAX_C;
    room2    = {1'b0, wcnt_r} + (CW + 1)'(2) <= MAX_C;
    rstart   = {1'b0, frs_r} + {1'b0, fg_r};
    dst      = (rd_ix_r < fidx_r) ? rd_ix_r : rd_ix_r + CW'(k_r);
    spc_addr = fidx_r + CW'(spc_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_item.op;
          s_nxt        = in_item.start_position;
          n_nxt        = n_eff;
          dn_nxt       = dn;
          e_nxt        = {1'b0, in_item.start_position} + {1'b0, dn};
          v_nxt        = v64[PW-1:0];
          wb_nxt       = do_del ? ~cur_r : cur_r;
          wcnt_nxt     = cnt_r;
          wend_nxt     = end_r;
          rd_idx_nxt   = '0;
          wr_idx_nxt   = '0;
          pos_nxt      = '0;
          carry_nxt    = '0;
          base_nxt     = '0;
          found_nxt    = 1'b0;
          out_item_nxt = '0;
          if (is_mod && (n_eff == '0)) begin
            state_nxt = S_FIN0;
          end else if (do_del) begin
            state_nxt = S_DEL;
          end else if ((in_item.op == rlim_pkg::OP_SET) ||
                       (in_item.op == rlim_pkg::OP_CLEAR) ||
                       (in_item.op == rlim_pkg::OP_INSERT) ||
                       (in_item.op == rlim_pkg::OP_LOOKUP)) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_FIN0;
          end
        end
      end

      // Stream the current bank into the other one, dropping the range.
      S_DEL: begin
        issue = rd_idx_r < cnt_r;
        mem_ctl.rd_en   = issue;
        mem_ctl.rd_bank = cur_r;
        rd_addr         = rd_idx_r[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          pos_nxt = re_;
          if (nl == '0) begin
            carry_nxt = carry_r + ng;
          end else begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_bank = ~cur_r;
            wr_addr         = wr_idx_r[AW-1:0];
            wr_data         = {32'(carry_r + ng), 32'(nl), d_pay};
            wr_idx_nxt      = wr_idx_r + CW'(1);
            carry_nxt       = '0;
          end
        end else if (!issue) begin
          wcnt_nxt   = wr_idx_r;
          wend_nxt   = end_r - dn_r - carry_r[31:0];
          rd_idx_nxt = '0;
          base_nxt   = '0;
          if (op_r == rlim_pkg::OP_DELETE) begin
            cur_nxt   = ~cur_r;
            cnt_nxt   = wr_idx_r;
            end_nxt   = end_r - dn_r - carry_r[31:0];
            state_nxt = S_FIN0;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      // Walk the working bank to the record that covers the position.
      S_FIND: begin
        issue = (rd_idx_r < wcnt_r) && (s_r < wend_r);
        mem_ctl.rd_en   = issue;
        mem_ctl.rd_bank = wb_r;
        rd_addr         = rd_idx_r[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_ix_nxt  = rd_idx_r;
          rd_vld_nxt = 1'b1;
        end
        if (hit) begin
          found_nxt  = 1'b1;
          fidx_nxt   = rd_ix_r;
          fg_nxt     = d_gap;
          fl_nxt     = d_len;
          fp_nxt     = d_pay;
          frs_nxt    = base_r[31:0];
          rd_vld_nxt = 1'b0;
          state_nxt  = S_ACT;
        end else if (rd_vld_r) begin
          base_nxt = nxt_base;
        end else if (miss_done) begin
          found_nxt = 1'b0;
          state_nxt = S_ACT;
        end
      end

      // Decide the change and apply it in place, or set up a copy pass.
      S_ACT: begin
        state_nxt  = S_FIN0;
        rd_idx_nxt = '0;
        spc_nxt    = '0;
        case (op_r)
          rlim_pkg::OP_LOOKUP: begin
            if (found_r) begin
              out_item_nxt.found = 1'b1;
              if ({1'b0, s_r} >= rstart) begin
                out_item_nxt.is_run      = 1'b1;
                out_item_nxt.span_start  = rstart[31:0];
                out_item_nxt.span_length = fl_r;
                out_item_nxt.span_value  = p64[31:0];
              end else begin
                out_item_nxt.span_start  = frs_r;
                out_item_nxt.span_length = fg_r;
              end
            end else begin
              out_item_nxt.span_start = end_r;
            end
          end
          rlim_pkg::OP_INSERT: begin
            if (found_r) begin
              mem_ctl.wr_en   = 1'b1;
              mem_ctl.wr_bank = wb_r;
              wr_addr         = fidx_r[AW-1:0];
              wr_data         = split ? {fg_r, fl_r + n_r, fp_r} : {fg_r + n_r, fl_r, fp_r};
              end_nxt         = end_r + n_r;
            end
          end
          rlim_pkg::OP_CLEAR: begin
            if (!found_r) begin
              cur_nxt = wb_r;
              cnt_nxt = wcnt_r;
              end_nxt = wend_r;
            end else if (!split) begin
              mem_ctl.wr_en   = 1'b1;
              mem_ctl.wr_bank = wb_r;
              wr_addr         = fidx_r[AW-1:0];
              wr_data         = {fg_r + n_r, fl_r, fp_r};
              cur_nxt         = wb_r;
              cnt_nxt         = wcnt_r;
              end_nxt         = wend_r + n_r;
            end else if (!room1) begin
              out_item_nxt.fail = 1'b1;
            end else begin
              k_nxt     = 2'd1;
              sp_nxt[0] = {fg_r, head, fp_r};
              sp_nxt[1] = {n_r, fl_r - head, fp_r};
              state_nxt = S_COPY;
            end
          end
          rlim_pkg::OP_SET: begin
            if (!found_r) begin
              if (!room1) begin
                out_item_nxt.fail = 1'b1;
              end else begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_bank = wb_r;
                wr_addr         = wcnt_r[AW-1:0];
                wr_data         = {s_r - wend_r, n_r, v_r};
                cur_nxt         = wb_r;
                cnt_nxt         = wcnt_r + CW'(1);
                end_nxt         = s_r + n_r;
              end
            end else if (split) begin
              if (!room2) begin
                out_item_nxt.fail = 1'b1;
              end else begin
                k_nxt     = 2'd2;
                sp_nxt[0] = {fg_r, head, fp_r};
                sp_nxt[1] = {32'd0, n_r, v_r};
                sp_nxt[2] = {32'd0, fl_r - head, fp_r};
                state_nxt = S_COPY;
              end
            end else if (!room1) begin
              out_item_nxt.fail = 1'b1;
            end else begin
              k_nxt     = 2'd1;
              sp_nxt[0] = {off, n_r, v_r};
              sp_nxt[1] = {fg_r - off, fl_r, fp_r};
              state_nxt = S_COPY;
            end
          end
          default: begin
          end
        endcase
      end

      // Copy the working bank across, leaving room at the found record.
      S_COPY: begin
        issue = rd_idx_r < wcnt_r;
        mem_ctl.rd_en   = issue;
        mem_ctl.rd_bank = wb_r;
        rd_addr         = rd_idx_r[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          rd_ix_nxt  = rd_idx_r;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_ix_r != fidx_r) begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_bank = ~wb_r;
            wr_addr         = dst[AW-1:0];
            wr_data         = rd_data;
          end
        end else if (!issue) begin
          state_nxt = S_SPEC;
        end
      end

      // Write the new records into the opened slots, then commit.
      S_SPEC: begin
        mem_ctl.wr_en   = 1'b1;
        mem_ctl.wr_bank = ~wb_r;
        wr_addr         = spc_addr[AW-1:0];
        wr_data         = sp_r[spc_r];
        spc_nxt         = spc_r + 2'd1;
        if (spc_r == k_r) begin
          cur_nxt   = ~wb_r;
          cnt_nxt   = wcnt_r + CW'(k_r);
          end_nxt   = wend_r + n_r;
          state_nxt = S_FIN0;
        end
      end

      S_FIN0: begin
        mem_ctl.rd_en   = 1'b1;
        mem_ctl.rd_bank = cur_r;
        rd_addr         = '0;
        state_nxt       = S_FIN1;
      end

      S_FIN1: begin
        out_item_nxt.line_length = end_r;
        out_item_nxt.first_used  = ((end_r != '0) && (cnt_r != '0)) ? d_gap : 32'd0;
        out_strobe_nxt           = 1'b1;
        state_nxt                = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= 1'b0;
      wb_r         <= 1'b0;
      cnt_r        <= '0;
      end_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      wb_r         <= wb_nxt;
      cnt_r        <= cnt_nxt;
      end_r        <= end_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Work and result registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    s_r        <= s_nxt;
    n_r        <= n_nxt;
    dn_r       <= dn_nxt;
    e_r        <= e_nxt;
    v_r        <= v_nxt;
    wcnt_r     <= wcnt_nxt;
    wend_r     <= wend_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_ix_r    <= rd_ix_nxt;
    wr_idx_r   <= wr_idx_nxt;
    pos_r      <= pos_nxt;
    carry_r    <= carry_nxt;
    base_r     <= base_nxt;
    found_r    <= found_nxt;
    fidx_r     <= fidx_nxt;
    fg_r       <= fg_nxt;
    fl_r       <= fl_nxt;
    fp_r       <= fp_nxt;
    frs_r      <= frs_nxt;
    k_r        <= k_nxt;
    spc_r      <= spc_nxt;
    sp_r       <= sp_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

>>> rtl/core/run_length_interval_map.sv
// Run-length interval map: an ordered table of gap / run / payload records.
// Input channel: an item (in_item) is taken at a rising edge with start high
// and busy low. busy stays high until the result has been produced.
// Result channel: exactly one result item per input item, shown on out_item
// for one cycle with out_strobe high. The receiver cannot stall it.
// Every record pass streams one record per clock through a table memory
// with a registered read. Lookup and insert walk the table in a search pass;
// delete runs a delete pass only; set and clear may run a delete pass, a
// search pass and a copy pass into the second bank.
// The table lives in two banks; a modifying pass writes the other bank and
// only switches over when the operation succeeds, so a failed set or clear
// leaves the table as it was.
// Reset empties the table (record count and line end go to zero); no clearing
// pass is needed and the block is ready right after it.
module run_length_interval_map #(
  parameter int MAX_RECORDS   = rlim_pkg::MAX_RECORDS_DEF,
  parameter int PAYLOAD_WIDTH = rlim_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rlim_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_strobe,
  output rlim_pkg::out_item_t out_item
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int RW = 2 * rlim_pkg::POS_W + PAYLOAD_WIDTH;

  rlim_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [RW-1:0] wr_data, rd_data, rdata0, rdata1;
  logic          rd_bank_r;

  rlim_seq #(
    .MAX_RECORDS  (MAX_RECORDS),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  rlim_bank #(
    .DEPTH(MAX_RECORDS),
    .WIDTH(RW)
  ) u_bank0 (
    .clk  (clk),
    .we   (mem_ctl.wr_en && !mem_ctl.wr_bank),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (mem_ctl.rd_en && !mem_ctl.rd_bank),
    .raddr(rd_addr),
    .rdata(rdata0)
  );

  rlim_bank #(
    .DEPTH(MAX_RECORDS),
    .WIDTH(RW)
  ) u_bank1 (
    .clk  (clk),
    .we   (mem_ctl.wr_en && mem_ctl.wr_bank),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (mem_ctl.rd_en && mem_ctl.rd_bank),
    .raddr(rd_addr),
    .rdata(rdata1)
  );

  // Read data comes from a registered port, so remember which bank was read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_bank_r <= 1'b0;
    end else if (mem_ctl.rd_en) begin
      rd_bank_r <= mem_ctl.rd_bank;
    end
  end

  assign rd_data = rd_bank_r ? rdata1 : rdata0;

  // A streaming pass never reads and writes the same bank in one cycle.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.rd_en && mem_ctl.wr_en) |-> (mem_ctl.rd_bank != mem_ctl.wr_bank))
    else $error("read and write hit the same bank");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without preceding work");

endmodule
